// ===== src/fa_pkg.sv =====
`timescale 1ns / 1ps
package fa_pkg;

  // fixed field widths at the ports
  localparam int SIZE_W    = 20;
  localparam int IDX_OUT_W = 6;
  localparam int STATUS_W  = 2;
  localparam int MODE_W    = 2;

  // defaults for the top-level parameters
  localparam int MAX_BLOCKS_DEF = 64;
  localparam int SIZE_BITS_DEF  = 20;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_FIT_MODE = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

endpackage

// ===== src/fit_allocator_with_split.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake              | payload
// in_     | input     | in_valid / in_stall    | opcode, size
// out_    | output    | out_valid / out_stall  | status, block_index, block_size, remainder_size
// cfg_    | input     | apb write/read         | fit_mode at byte address 0
//
// one item at a time; the block table lives in one ram (size plus free mark per entry)
// add: the table write on the accepting edge, then the result register
// allocate: the accepting cycle, a scan through the ram read port up to the last entry,
//   a decide state, a shift and drain when a remainder is inserted above a non-last pick,
//   the remainder and pick writes (only the pick write on an exact fit), and the result state
// reset clears state, count, fit mode and both valid flags; the ram needs no clearing pass
// a finished result waits in the output register while the next item is accepted;
//   a result blocked behind a stalled output holds the sequencer in its last state
module fit_allocator_with_split
  import fa_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_opcode,
  input  logic [SIZE_W-1:0]     in_size,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [IDX_OUT_W-1:0]  out_block_index,
  output logic [SIZE_W-1:0]     out_block_size,
  output logic [SIZE_W-1:0]     out_remainder_size,
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int ENT_W = SIZE_BITS + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_DRAIN,
    S_WR_REM,
    S_WR_PICK,
    S_FINISH
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     count_r;
  logic [MODE_W-1:0]    fit_mode_r;
  logic [SIZE_BITS-1:0] req_r;
  logic [IDX_W-1:0]     sc_r;
  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 found_r;
  logic [IDX_W-1:0]     pick_r;
  logic [SIZE_BITS-1:0] best_r;
  logic [IDX_W-1:0]     sh_r;
  logic [SIZE_BITS-1:0] rem_r;
  status_t              res_status_r;
  logic [IDX_W-1:0]     res_idx_r;
  logic [SIZE_BITS-1:0] res_bsize_r;
  logic [SIZE_BITS-1:0] res_rem_r;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic [SIZE_W-1:0]    out_bsize_r;
  logic [SIZE_W-1:0]    out_rem_r;

  // ram ports
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENT_W-1:0]     ram_rdata;
  logic                 rd_issue;

  fa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // width adaption of the size fields
  logic [SIZE_W+SIZE_BITS-1:0]  in_size_ext;
  logic [SIZE_BITS-1:0]         in_size_s;
  logic [CNT_W-1:0]             cnt_m1;
  logic [IDX_W-1:0]             last_idx;
  logic                         tbl_full;

  assign in_size_ext = {{SIZE_BITS{1'b0}}, in_size};
  assign in_size_s   = in_size_ext[SIZE_BITS-1:0];
  assign cnt_m1      = count_r - CNT_W'(1);
  assign last_idx    = cnt_m1[IDX_W-1:0];
  assign tbl_full    = (count_r == CNT_W'(MAX_BLOCKS));

  // scan compare on the entry coming out of the ram
  logic [SIZE_BITS-1:0] sc_size;
  logic                 sc_free;
  logic                 sc_fits;
  logic                 sc_better;
  logic                 first_mode;
  logic                 sc_done;
  logic [SIZE_BITS-1:0] dec_rem;

  assign sc_size    = ram_rdata[SIZE_BITS-1:0];
  assign sc_free    = ram_rdata[SIZE_BITS];
  assign sc_fits    = rd_vld_r && sc_free && (sc_size >= req_r);
  assign first_mode = (fit_mode_r != FIT_BEST) && (fit_mode_r != FIT_WORST);
  assign sc_better  = !found_r
                   || ((fit_mode_r == FIT_BEST)  && (sc_size < best_r))
                   || ((fit_mode_r == FIT_WORST) && (sc_size > best_r));
  // stop on the last entry, or on the first fit in first-fit mode
  assign sc_done    = rd_vld_r && ((rd_idx_r == last_idx) || (sc_fits && first_mode));
  assign dec_rem    = best_r - req_r;

  assign in_stall = (state_r != S_IDLE);

  // ram port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    rd_issue  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // append goes straight into the table on the accepting edge
        if (in_valid && (in_opcode == OP_ADD) && !tbl_full) begin
          ram_we    = 1'b1;
          ram_waddr = count_r[IDX_W-1:0];
          ram_wdata = {1'b1, in_size_s};
        end
      end
      S_SCAN: begin
        ram_raddr = sc_r;
        rd_issue  = 1'b1;
      end
      S_SHIFT: begin
        // read entry sh_r, write the entry returned for the last read one place up
        ram_raddr = sh_r;
        rd_issue  = 1'b1;
        if (rd_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_r + IDX_W'(1);
          ram_wdata = ram_rdata;
        end
      end
      S_DRAIN: begin
        if (rd_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = rd_idx_r + IDX_W'(1);
          ram_wdata = ram_rdata;
        end
      end
      S_WR_REM: begin
        ram_we    = 1'b1;
        ram_waddr = pick_r + IDX_W'(1);
        ram_wdata = {1'b1, rem_r};
      end
      S_WR_PICK: begin
        ram_we    = 1'b1;
        ram_waddr = pick_r;
        ram_wdata = {1'b0, req_r};
      end
      default: begin
      end
    endcase
  end

  // result field widths at the port
  logic [IDX_W+IDX_OUT_W-1:0]  res_idx_ext;
  logic [SIZE_BITS+SIZE_W-1:0] res_bsize_ext;
  logic [SIZE_BITS+SIZE_W-1:0] res_rem_ext;

  assign res_idx_ext   = {{IDX_OUT_W{1'b0}}, res_idx_r};
  assign res_bsize_ext = {{SIZE_W{1'b0}}, res_bsize_r};
  assign res_rem_ext   = {{SIZE_W{1'b0}}, res_rem_r};

  // sequencer, table count, fit mode and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      fit_mode_r  <= FIT_FIRST;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_issue;
      rd_idx_r <= ram_raddr;

      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
          && (cfg_paddr[2] == REG_FIT_MODE)) begin
        fit_mode_r <= cfg_pwdata[MODE_W-1:0];
      end

      // output register empties on a transfer, unless a new result refills it
      if (out_valid_r && !out_stall && (state_r != S_FINISH)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_size_s;
            found_r <= 1'b0;
            if (in_opcode == OP_ADD) begin
              if (tbl_full) begin
                res_status_r <= ST_FULL;
                res_idx_r    <= '0;
                res_bsize_r  <= '0;
              end else begin
                res_status_r <= ST_OK;
                res_idx_r    <= count_r[IDX_W-1:0];
                res_bsize_r  <= in_size_s;
                count_r      <= count_r + CNT_W'(1);
              end
              res_rem_r <= '0;
              state_r   <= S_FINISH;
            end else if (count_r == '0) begin
              // empty table: nothing can fit
              res_status_r <= ST_NO_FIT;
              res_idx_r    <= '0;
              res_bsize_r  <= '0;
              res_rem_r    <= '0;
              state_r      <= S_FINISH;
            end else begin
              sc_r    <= '0;
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          sc_r <= sc_r + IDX_W'(1);
          if (sc_fits && sc_better) begin
            found_r <= 1'b1;
            pick_r  <= rd_idx_r;
            best_r  <= sc_size;
          end
          if (sc_done) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!found_r) begin
            res_status_r <= ST_NO_FIT;
            res_idx_r    <= '0;
            res_bsize_r  <= '0;
            res_rem_r    <= '0;
            state_r      <= S_FINISH;
          end else if (dec_rem == '0) begin
            // exact fit: mark taken, no remainder entry
            rem_r   <= '0;
            state_r <= S_WR_PICK;
          end else if (tbl_full) begin
            res_status_r <= ST_FULL;
            res_idx_r    <= '0;
            res_bsize_r  <= '0;
            res_rem_r    <= '0;
            state_r      <= S_FINISH;
          end else begin
            rem_r <= dec_rem;
            if (pick_r == last_idx) begin
              state_r <= S_WR_REM;
            end else begin
              sh_r    <= last_idx;
              state_r <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (sh_r == pick_r + IDX_W'(1)) begin
            state_r <= S_DRAIN;
          end else begin
            sh_r <= sh_r - IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state_r <= S_WR_REM;
        end
        S_WR_REM: begin
          count_r <= count_r + CNT_W'(1);
          state_r <= S_WR_PICK;
        end
        S_WR_PICK: begin
          res_status_r <= ST_OK;
          res_idx_r    <= pick_r;
          res_bsize_r  <= req_r;
          res_rem_r    <= rem_r;
          state_r      <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_idx_r    <= res_idx_ext[IDX_OUT_W-1:0];
            out_bsize_r  <= res_bsize_ext[SIZE_W-1:0];
            out_rem_r    <= res_rem_ext[SIZE_W-1:0];
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_block_index    = out_idx_r;
  assign out_block_size     = out_bsize_r;
  assign out_remainder_size = out_rem_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_FIT_MODE)
                    ? {{(CFG_DATA_W-MODE_W){1'b0}}, fit_mode_r}
                    : '0;

endmodule

// ===== src/fa_ram.sv =====
`timescale 1ns / 1ps
module fa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/fa_checker.sv =====
`timescale 1ns / 1ps
module fa_checker
  import fa_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  in_opcode,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [STATUS_W-1:0]   out_status,
  input logic [IDX_OUT_W-1:0]  out_block_index,
  input logic [SIZE_W-1:0]     out_block_size,
  input logic [SIZE_W-1:0]     out_remainder_size
);

  logic work_op_r;
  logic held_r;

  // op of the item in work, and whether the shown result was already shown
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_op_r <= OP_ADD;
      held_r    <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        work_op_r <= in_opcode;
      end
      held_r <= out_valid && out_stall;
    end
  end

  // a stalled result holds its valid, status, index and remainder
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_block_index) && $stable(out_remainder_size))
    else $error("stalled result changed");

  // one item at a time: the cycle after a transfer in, no further transfer in
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  // refused or unfitted items carry zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      (out_block_index == '0) && (out_block_size == '0) && (out_remainder_size == '0))
    else $error("nonzero fields on a failed item");

  // an append never reports a remainder, checked when its result first shows
  a_add_no_rem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !held_r && (work_op_r == OP_ADD) |-> (out_remainder_size == '0))
    else $error("remainder on an append");

endmodule

bind fit_allocator_with_split fa_checker u_fa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_opcode          (in_opcode),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_block_index    (out_block_index),
  .out_block_size     (out_block_size),
  .out_remainder_size (out_remainder_size)
);
